// File: rtl/core/pst_pkg.sv
package pst_pkg;

  // sizing of the job store and of the job fields
  localparam int unsigned MaxProcesses = 32;
  localparam int unsigned BurstBits    = 16;
  localparam int unsigned PriorityBits = 8;

  // store index and job count widths
  localparam int unsigned IdxW = $clog2(MaxProcesses);
  localparam int unsigned CntW = $clog2(MaxProcesses + 1);

  // internal time and sum widths
  localparam int unsigned ElapW = BurstBits + IdxW;
  localparam int unsigned SumW  = ElapW + IdxW;

  // fixed result field widths
  localparam int unsigned ProcIdW  = 6;
  localparam int unsigned JobPrioW = 8;
  localparam int unsigned JobBurstW = 16;
  localparam int unsigned TimeW    = 21;

  typedef struct packed {
    logic [BurstBits-1:0]    burst_time;
    logic [PriorityBits-1:0] priority_req;
    logic                    last_process;
  } pst_in_t;

  typedef struct packed {
    logic [ProcIdW-1:0]   process_id;
    logic [JobPrioW-1:0]  job_priority;
    logic [JobBurstW-1:0] job_burst;
    logic [TimeW-1:0]     waiting_time;
    logic [TimeW-1:0]     completion_time;
    logic [TimeW-1:0]     turnaround_time;
    logic [TimeW-1:0]     avg_waiting;
    logic [TimeW-1:0]     avg_turnaround;
    logic                 overflowed;
    logic                 last_result;
  } pst_out_t;

  // one entry of the job store
  typedef struct packed {
    logic [CntW-1:0]         id;
    logic [PriorityBits-1:0] prio;
    logic [BurstBits-1:0]    burst;
  } pst_job_t;

  localparam int unsigned JobW = $bits(pst_job_t);

endpackage

// File: rtl/core/priority_schedule_times.sv
// non-preemptive priority scheduler for one set of jobs
// input channel (in_valid_i / in_ready_o / in_req_i): one request per job,
// burst time and priority; last_process closes the set. ids run from 1 in
// arrival order. jobs beyond the store depth are dropped and flagged.
// ready is high only while loading.
// after the closing request the block sorts by descending priority (first
// strictly greater priority wins, so a tie goes to the lower store position,
// which after earlier swaps need not be the earlier arrival), sums the times,
// divides both sums by the job count and emits one result request per job on
// (out_valid_o / out_ready_i / out_rsp_o).
// from the closing request to the first result the block runs the sort (one
// store read per compared entry plus a swap in StSw1 and StSw2 per position),
// the summing pass, the two serial divisions and the load of the first result.
// each further result takes one store read and one output load.
// a stalled receiver holds the output register and the emit sequencer
// waits; the final result may sit in the output register while a new set
// is loaded. reset clears the job count, the drop flag and all control
// state; the job store itself needs no clearing since only written
// entries are ever read.
module priority_schedule_times (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pst_pkg::pst_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pst_pkg::pst_out_t out_rsp_o
);

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StRdI   = 11'b00000000010,
    StFirst = 11'b00000000100,
    StScan  = 11'b00000001000,
    StSw1   = 11'b00000010000,
    StSw2   = 11'b00000100000,
    StSum   = 11'b00001000000,
    StDivW  = 11'b00010000000,
    StDivT  = 11'b00100000000,
    StERd   = 11'b01000000000,
    StELd   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // set bookkeeping
  logic [pst_pkg::CntW-1:0] count_q, count_d;
  logic                     drop_q, drop_d;

  // sort and pass indices
  logic [pst_pkg::CntW-1:0] i_q, i_d;
  logic [pst_pkg::CntW-1:0] j_q, j_d;
  logic [pst_pkg::IdxW-1:0] jr_q, jr_d;
  logic [pst_pkg::IdxW-1:0] sel_q, sel_d;
  logic                     rv_q, rv_d;

  // entry under position i and best candidate so far
  pst_pkg::pst_job_t cur_q, cur_d;
  pst_pkg::pst_job_t best_q, best_d;

  // time accumulators and averages
  logic [pst_pkg::ElapW-1:0] elap_q, elap_d;
  logic [pst_pkg::SumW-1:0]  sumw_q, sumw_d;
  logic [pst_pkg::SumW-1:0]  sumt_q, sumt_d;
  logic [pst_pkg::TimeW-1:0] avgw_q, avgw_d;
  logic [pst_pkg::TimeW-1:0] avgt_q, avgt_d;
  logic [pst_pkg::ElapW-1:0] elap_next;

  // output register
  logic              out_valid_q, out_valid_d;
  pst_pkg::pst_out_t out_q, out_d;

  // store ports
  logic                     ram_we, ram_re;
  logic [pst_pkg::IdxW-1:0] ram_waddr, ram_raddr;
  pst_pkg::pst_job_t        ram_wdata, ram_rdata;

  // divider
  logic                     div_start;
  logic                     div_done;
  logic [pst_pkg::SumW-1:0] div_dividend;
  logic [pst_pkg::SumW-1:0] div_quot;

  logic in_fire;
  logic out_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign elap_next  = elap_q + pst_pkg::ElapW'(ram_rdata.burst);

  // first division takes the waiting sum, the second the turnaround sum
  assign div_dividend = (state_q == StDivW) ? sumt_q : sumw_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    i_d         = i_q;
    j_d         = j_q;
    jr_d        = jr_q;
    sel_d       = sel_q;
    rv_d        = 1'b0;
    cur_d       = cur_q;
    best_d      = best_q;
    elap_d      = elap_q;
    sumw_d      = sumw_q;
    sumt_d      = sumt_q;
    avgw_d      = avgw_q;
    avgt_d      = avgt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = i_q[pst_pkg::IdxW-1:0];
    ram_wdata   = best_q;
    ram_re      = 1'b0;
    ram_raddr   = i_q[pst_pkg::IdxW-1:0];
    div_start   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (count_q < pst_pkg::CntW'(pst_pkg::MaxProcesses)) begin
            ram_we          = 1'b1;
            ram_waddr       = count_q[pst_pkg::IdxW-1:0];
            ram_wdata.id    = count_q + pst_pkg::CntW'(1);
            ram_wdata.prio  = in_req_i.priority_req;
            ram_wdata.burst = in_req_i.burst_time;
            count_d         = count_q + pst_pkg::CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_req_i.last_process) begin
            i_d     = '0;
            state_d = StRdI;
          end
        end
      end

      // start position i, or leave once a single entry is left
      StRdI: begin
        if (i_q + pst_pkg::CntW'(1) >= count_q) begin
          j_d     = '0;
          elap_d  = '0;
          sumw_d  = '0;
          sumt_d  = '0;
          state_d = StSum;
        end else begin
          ram_re  = 1'b1;
          j_d     = i_q + pst_pkg::CntW'(1);
          state_d = StFirst;
        end
      end

      StFirst: begin
        cur_d     = ram_rdata;
        best_d    = ram_rdata;
        sel_d     = i_q[pst_pkg::IdxW-1:0];
        ram_re    = 1'b1;
        ram_raddr = j_q[pst_pkg::IdxW-1:0];
        jr_d      = j_q[pst_pkg::IdxW-1:0];
        j_d       = j_q + pst_pkg::CntW'(1);
        state_d   = StScan;
      end

      StScan: begin
        if (ram_rdata.prio > best_q.prio) begin
          best_d = ram_rdata;
          sel_d  = jr_q;
        end
        if (j_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = j_q[pst_pkg::IdxW-1:0];
          jr_d      = j_q[pst_pkg::IdxW-1:0];
          j_d       = j_q + pst_pkg::CntW'(1);
        end else begin
          state_d = StSw1;
        end
      end

      StSw1: begin
        ram_we    = 1'b1;
        ram_waddr = i_q[pst_pkg::IdxW-1:0];
        ram_wdata = best_q;
        state_d   = StSw2;
      end

      StSw2: begin
        ram_we    = 1'b1;
        ram_waddr = sel_q;
        ram_wdata = cur_q;
        i_d       = i_q + pst_pkg::CntW'(1);
        state_d   = StRdI;
      end

      // stream the sorted store once to build both sums
      StSum: begin
        if (j_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = j_q[pst_pkg::IdxW-1:0];
          j_d       = j_q + pst_pkg::CntW'(1);
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          sumw_d = sumw_q + pst_pkg::SumW'(elap_q);
          sumt_d = sumt_q + pst_pkg::SumW'(elap_next);
          elap_d = elap_next;
        end
        if (!rv_q && (j_q >= count_q)) begin
          div_start = 1'b1;
          state_d   = StDivW;
        end
      end

      StDivW: begin
        if (div_done) begin
          avgw_d    = div_quot[pst_pkg::TimeW-1:0];
          div_start = 1'b1;
          state_d   = StDivT;
        end
      end

      StDivT: begin
        if (div_done) begin
          avgt_d  = div_quot[pst_pkg::TimeW-1:0];
          i_d     = '0;
          elap_d  = '0;
          state_d = StERd;
        end
      end

      StERd: begin
        ram_re  = 1'b1;
        state_d = StELd;
      end

      // wait for a free output register, then load one result
      StELd: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.process_id      = pst_pkg::ProcIdW'(ram_rdata.id);
          out_d.job_priority    = pst_pkg::JobPrioW'(ram_rdata.prio);
          out_d.job_burst       = pst_pkg::JobBurstW'(ram_rdata.burst);
          out_d.waiting_time    = pst_pkg::TimeW'(elap_q);
          out_d.completion_time = pst_pkg::TimeW'(elap_next);
          out_d.turnaround_time = pst_pkg::TimeW'(elap_next);
          out_d.avg_waiting     = avgw_q;
          out_d.avg_turnaround  = avgt_q;
          out_d.overflowed      = drop_q;
          out_d.last_result     = (i_q + pst_pkg::CntW'(1) == count_q);
          elap_d                = elap_next;
          i_d                   = i_q + pst_pkg::CntW'(1);
          if (i_q + pst_pkg::CntW'(1) == count_q) begin
            count_d = '0;
            drop_d  = 1'b0;
            state_d = StIdle;
          end else begin
            state_d = StERd;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      drop_q      <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    jr_q   <= jr_d;
    sel_q  <= sel_d;
    cur_q  <= cur_d;
    best_q <= best_d;
    elap_q <= elap_d;
    sumw_q <= sumw_d;
    sumt_q <= sumt_d;
    avgw_q <= avgw_d;
    avgt_q <= avgt_d;
    out_q  <= out_d;
  end

  pst_ram #(
    .Width(pst_pkg::JobW),
    .Depth(pst_pkg::MaxProcesses)
  ) u_job_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pst_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: rtl/core/pst_ram.sv
module pst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pst_div.sv
module pst_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [pst_pkg::SumW-1:0] dividend_i,
  input  logic [pst_pkg::CntW-1:0] divisor_i,
  output logic                     done_o,
  output logic [pst_pkg::SumW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(pst_pkg::SumW);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [StepW-1:0]         step_q, step_d;
  logic [pst_pkg::SumW-1:0] dvd_q, dvd_d;
  logic [pst_pkg::CntW-1:0] rem_q, rem_d;
  logic [pst_pkg::CntW-1:0] dsr_q, dsr_d;
  logic [pst_pkg::CntW:0]   rem_sh;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q, dvd_q[pst_pkg::SumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(pst_pkg::SumW - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = pst_pkg::CntW'(rem_sh - {1'b0, dsr_q});
        dvd_d = {dvd_q[pst_pkg::SumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[pst_pkg::CntW-1:0];
        dvd_d = {dvd_q[pst_pkg::SumW-2:0], 1'b0};
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// File: rtl/core/pst_checker.sv
module pst_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input pst_pkg::pst_in_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pst_pkg::pst_out_t out_rsp_o
);

  // a stalled result request stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  // a stalled result request keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("result payload changed while stalled");

  // ready drops after the closing job of a set is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.last_process |=> !in_ready_o)
    else $error("input accepted right after the closing job");

  // no loading while a run still has results to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.last_result |-> !in_ready_o)
    else $error("input ready in the middle of a run");

endmodule

bind priority_schedule_times pst_checker u_pst_checker (.*);
